[design/utn_pkg.sv]
// Shared types and constants for the UTF-8 text normalizer.
// Used by utn_core and utf8_text_normalizer. No dependencies.
`default_nettype none

package utn_pkg;

    // Code point constants.
    localparam logic [20:0] FW_LO       = 21'h00FF01;
    localparam logic [20:0] FW_HI       = 21'h00FF5E;
    localparam logic [20:0] FW_OFS      = 21'h00FEE0;
    localparam logic [20:0] IDEO_SPACE  = 21'h003000;
    localparam logic [20:0] CP_SPACE    = 21'h000020;
    localparam logic [20:0] CP_TAB      = 21'h000009;
    localparam logic [20:0] CP_UPPER_A  = 21'h000041;
    localparam logic [20:0] CP_UPPER_Z  = 21'h00005A;
    localparam logic [20:0] CP_CASE_OFS = 21'h000020;
    localparam logic [20:0] CP_LIM1     = 21'h000080;
    localparam logic [20:0] CP_LIM2     = 21'h000800;
    localparam logic [20:0] CP_LIM3     = 21'h010000;

    // Lead byte boundaries and the space byte.
    localparam logic [7:0] LEAD3      = 8'hE0;
    localparam logic [7:0] LEAD4      = 8'hF0;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Maximum number of bytes one input word can produce.
    localparam int unsigned GRP_DEPTH = 5;

    // Decoder state carried from one input word to the next.
    typedef struct packed {
        logic [20:0] acc;   // code point being assembled
        logic [1:0]  left;  // continuation bytes still expected
        logic        seen;  // last code point was a space, or text start
        logic        pend;  // one collapsed space is held back
    } t_state;

    localparam t_state ST_RESET = '{acc: 21'd0, left: 2'd0, seen: 1'b1, pend: 1'b0};

    // Bytes produced by one input word, lowest index sent first.
    typedef struct packed {
        logic [GRP_DEPTH-1:0][7:0] bytes;
        logic [2:0]                cnt;   // number of result words, 0 to 5
        logic                      bare;  // the single result is a bare end marker
        logic                      last;  // final result word closes the text
    } t_group;

endpackage

`default_nettype wire

[design/utn_core.sv]
// Combinational decode, fold, collapse and re-encode step for one input byte.
// Depends on utn_pkg for the state and result group types.
`default_nettype none

module utn_core (
    input  var utn_pkg::t_state i_st,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    output utn_pkg::t_state     o_st,
    output utn_pkg::t_group     o_grp
);
    import utn_pkg::*;

    logic        code_vld;
    logic [20:0] cp;
    logic [20:0] acc_cat;
    logic [20:0] cp_f;
    logic [20:0] cp_l;
    logic        is_sp;
    logic [3:0][7:0] enc;
    logic [2:0]  enc_n;
    t_state      n_st;
    t_group      grp;

    assign acc_cat = {i_st.acc[14:0], i_byte[5:0]};

    // Sequence assembly: the lead byte alone sets the length.
    always_comb begin
        n_st     = i_st;
        code_vld = 1'b0;
        cp       = {13'd0, i_byte};
        if (i_st.left == 2'd0) begin
            if (!i_byte[7]) begin
                code_vld = 1'b1;
            end else if (i_byte < LEAD3) begin
                n_st.acc  = {16'd0, i_byte[4:0]};
                n_st.left = 2'd1;
            end else if (i_byte < LEAD4) begin
                n_st.acc  = {17'd0, i_byte[3:0]};
                n_st.left = 2'd2;
            end else begin
                n_st.acc  = {18'd0, i_byte[2:0]};
                n_st.left = 2'd3;
            end
        end else begin
            n_st.acc  = acc_cat;
            n_st.left = i_st.left - 2'd1;
            if (i_st.left == 2'd1) begin
                code_vld = 1'b1;
                cp       = acc_cat;
            end
        end
    end

    // Width folding, space detection and lower casing.
    always_comb begin
        cp_f = cp;
        if (cp >= FW_LO && cp <= FW_HI) begin
            cp_f = cp - FW_OFS;
        end
        if (cp_f == IDEO_SPACE) begin
            cp_f = CP_SPACE;
        end
        is_sp = (cp_f == CP_SPACE) || (cp_f == CP_TAB);
        cp_l  = cp_f;
        if (cp_f >= CP_UPPER_A && cp_f <= CP_UPPER_Z) begin
            cp_l = cp_f + CP_CASE_OFS;
        end
    end

    // Shortest-form encoding.
    always_comb begin
        enc = '0;
        if (cp_l < CP_LIM1) begin
            enc[0] = {1'b0, cp_l[6:0]};
            enc_n  = 3'd1;
        end else if (cp_l < CP_LIM2) begin
            enc[0] = {3'b110, cp_l[10:6]};
            enc[1] = {2'b10, cp_l[5:0]};
            enc_n  = 3'd2;
        end else if (cp_l < CP_LIM3) begin
            enc[0] = {4'b1110, cp_l[15:12]};
            enc[1] = {2'b10, cp_l[11:6]};
            enc[2] = {2'b10, cp_l[5:0]};
            enc_n  = 3'd3;
        end else begin
            enc[0] = {5'b11110, cp_l[20:18]};
            enc[1] = {2'b10, cp_l[17:12]};
            enc[2] = {2'b10, cp_l[11:6]};
            enc[3] = {2'b10, cp_l[5:0]};
            enc_n  = 3'd4;
        end
    end

    // Space collapsing, group assembly and end of text handling.
    always_comb begin
        o_st = n_st;
        grp  = '0;
        if (code_vld) begin
            if (is_sp) begin
                if (!i_st.seen) begin
                    o_st.pend = 1'b1;
                    o_st.seen = 1'b1;
                end
            end else begin
                o_st.seen = 1'b0;
                o_st.pend = 1'b0;
                if (i_st.pend) begin
                    grp.bytes[0]   = SPACE_BYTE;
                    grp.bytes[4:1] = enc;
                    grp.cnt        = enc_n + 3'd1;
                end else begin
                    grp.bytes[3:0] = enc;
                    grp.cnt        = enc_n;
                end
            end
        end
        if (i_last) begin
            // A cut-off sequence and a held space are simply dropped.
            o_st     = ST_RESET;
            grp.last = 1'b1;
            if (grp.cnt == 3'd0) begin
                grp.cnt  = 3'd1;
                grp.bare = 1'b1;
            end
        end
    end

    assign o_grp = grp;

endmodule

`default_nettype wire

[design/utf8_text_normalizer.sv]
// Top level of the UTF-8 text normalizer: input handshake, result group buffer
// and output register. Depends on utn_pkg and utn_core.
`default_nettype none

// Usage
// The slave channel takes one raw UTF-8 byte per word in i_s_tdata, with
// i_s_tlast on the final byte of a text. The master channel delivers the
// normalized text one byte per word in o_m_tdata; o_m_tuser is 1 when the word
// carries a byte and 0 for a bare end marker, and o_m_tlast closes the text.
// On the word that is accepted, utn_core decodes, folds and re-encodes in the
// same cycle, and the zero to five resulting bytes are loaded into a group
// buffer. The buffer feeds the output register one byte per cycle unless the
// receiver stalls; the first byte passes the buffer, then the output register.
// Throughput is one output byte per cycle without stalls, set by the single
// output register. Continuation bytes and collapsed spaces produce nothing and
// are taken every cycle while the buffer is empty; a byte that yields several
// results holds the input until the last leaves the buffer, so a plain ASCII
// stream runs at one byte per cycle without stalls. When the receiver stalls,
// the output register holds its word and the group buffer keeps the next bytes;
// input is refused while the buffer holds more than one byte or a stuck one.
// The output register lets one more group be taken while a finished byte waits.
// Synchronous reset (i_rst_n low) empties the buffer and output register and
// returns the decoder to text start: no partial sequence, no held space.
module utf8_text_normalizer (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,   // in_last
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic            o_m_tuser,   // [0] byte_present
    output logic            o_m_tlast    // out_last
);
    import utn_pkg::*;

    t_state r_st;
    t_state n_st;
    t_group n_grp;

    // Group buffer: control count plus payload.
    logic [2:0]                r_gcnt;
    logic [GRP_DEPTH-1:0][7:0] r_gbytes;
    logic                      r_gbare;
    logic                      r_glast;

    // Output register.
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_opres;
    logic       r_olast;

    logic move;
    logic accept;

    utn_core u_core (
        .i_st   (r_st),
        .i_byte (i_s_tdata),
        .i_last (i_s_tlast),
        .o_st   (n_st),
        .o_grp  (n_grp)
    );

    // The head of the group moves on whenever the output register is free or
    // being emptied. A new group may load as the last buffered byte leaves.
    assign move       = (r_gcnt != 3'd0) && (!r_ovalid || i_m_tready);
    assign o_s_tready = (r_gcnt == 3'd0) || ((r_gcnt == 3'd1) && move);
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_RESET;
            r_gcnt   <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_st   <= n_st;
                r_gcnt <= n_grp.cnt;
            end else if (move) begin
                r_gcnt <= r_gcnt - 3'd1;
            end
            if (move) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_gbytes <= n_grp.bytes;
            r_gbare  <= n_grp.bare;
            r_glast  <= n_grp.last;
        end else if (move) begin
            r_gbytes <= {8'h00, r_gbytes[GRP_DEPTH-1:1]};
        end
        if (move) begin
            r_obyte <= r_gbytes[0];
            r_opres <= !r_gbare;
            r_olast <= r_glast && (r_gcnt == 3'd1);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_obyte;
    assign o_m_tuser  = r_opres;
    assign o_m_tlast  = r_olast;

endmodule

`default_nettype wire

[design/utn_checker.sv]
// Port-level checks for utf8_text_normalizer, attached by a bind statement.
// Depends only on the top level's ports.
`default_nettype none

module utn_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] o_m_tdata,
    input wire logic       o_m_tuser,
    input wire logic       o_m_tlast
);

    // A stalled word stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output word withdrawn while stalled");

    // A stalled word keeps its payload.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_m_tvalid && !i_m_tready) |->
            $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output payload changed while stalled");

    // A bare end marker only ever closes a text.
    a_bare_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast)
        else $error("bare marker without last");

    // A bare end marker carries a zero byte.
    a_bare_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata == 8'h00))
        else $error("bare marker with nonzero byte");

    // A space is never the final byte of a text.
    a_no_trail_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast && o_m_tuser |-> (o_m_tdata != 8'h20))
        else $error("trailing space sent");

endmodule

bind utf8_text_normalizer utn_checker u_utn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

[tb/utn_stream_checker.sv]
// Scoreboard for the UTF-8 text normalizer: models the decode, fold and collapse rules,
// queues the predicted output words and compares them with the master channel.
// Stand-alone module with no package dependencies.
`default_nettype none

module utn_stream_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,   // in_last
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  wire logic       i_m_tuser,   // [0] byte_present
    input  wire logic       i_m_tlast,   // out_last
    output int              o_fail_count,
    output int              o_pending,
    output int              o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [20:0] FW_FIRST   = 21'h00FF01;
    localparam logic [20:0] FW_FINAL   = 21'h00FF5E;
    localparam logic [20:0] FW_SHIFT   = 21'h00FEE0;
    localparam logic [20:0] IDEO_SPACE = 21'h003000;
    localparam logic [20:0] ASCII_SP   = 21'h000020;
    localparam logic [20:0] ASCII_TAB  = 21'h000009;
    localparam logic [20:0] UPPER_A    = 21'h000041;
    localparam logic [20:0] UPPER_Z    = 21'h00005A;
    localparam logic [20:0] CASE_SHIFT = 21'h000020;
    localparam logic [20:0] LIMIT_1B   = 21'h000080;
    localparam logic [20:0] LIMIT_2B   = 21'h000800;
    localparam logic [20:0] LIMIT_3B   = 21'h010000;
    localparam logic [7:0]  LEAD_1B    = 8'h80;
    localparam logic [7:0]  LEAD_3B    = 8'hE0;
    localparam logic [7:0]  LEAD_4B    = 8'hF0;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_norm_word;

    t_norm_word  norm_q[$];     // expected output words, oldest first
    logic [20:0] cp_acc;        // code point under assembly
    logic [1:0]  cont_left;     // continuation bytes still owed
    logic        after_space;   // previous character was white space, or text start
    logic        space_held;    // one collapsed space waits for a visible character
    int          step_words;    // words produced by the current input word
    int          fails = 0;
    int          checked = 0;

    task automatic restart_text();
        cp_acc      = '0;
        cont_left   = '0;
        after_space = 1'b1;
        space_held  = 1'b0;
    endtask

    task automatic emit_byte(input logic [7:0] b, input logic present);
        t_norm_word w;
        w.data    = b;
        w.present = present;
        w.last    = 1'b0;
        norm_q.push_back(w);
        step_words++;
    endtask

    // Fold one decoded code point and queue its normalized UTF-8 bytes.
    task automatic fold_code(input logic [20:0] cp_in);
        logic [20:0] cp;
        cp = cp_in;
        if (cp >= FW_FIRST && cp <= FW_FINAL) cp = cp - FW_SHIFT;
        if (cp == IDEO_SPACE) cp = ASCII_SP;
        if (cp == ASCII_SP || cp == ASCII_TAB) begin
            if (!after_space) begin
                space_held  = 1'b1;
                after_space = 1'b1;
            end
        end else begin
            after_space = 1'b0;
            if (space_held) begin
                emit_byte(SPACE_CHAR, 1'b1);
                space_held = 1'b0;
            end
            if (cp >= UPPER_A && cp <= UPPER_Z) cp = cp + CASE_SHIFT;
            if (cp < LIMIT_1B) begin
                emit_byte(cp[7:0], 1'b1);
            end else if (cp < LIMIT_2B) begin
                emit_byte({3'b110, cp[10:6]}, 1'b1);
                emit_byte({2'b10, cp[5:0]}, 1'b1);
            end else if (cp < LIMIT_3B) begin
                emit_byte({4'b1110, cp[15:12]}, 1'b1);
                emit_byte({2'b10, cp[11:6]}, 1'b1);
                emit_byte({2'b10, cp[5:0]}, 1'b1);
            end else begin
                emit_byte({5'b11110, cp[20:18]}, 1'b1);
                emit_byte({2'b10, cp[17:12]}, 1'b1);
                emit_byte({2'b10, cp[11:6]}, 1'b1);
                emit_byte({2'b10, cp[5:0]}, 1'b1);
            end
        end
    endtask

    // Sequence length comes from the lead byte only; continuations are never checked.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        t_norm_word w;
        step_words = 0;
        if (cont_left == 2'd0) begin
            if (b < LEAD_1B) begin
                fold_code({13'd0, b});
            end else if (b < LEAD_3B) begin
                cp_acc    = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end else if (b < LEAD_4B) begin
                cp_acc    = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end else begin
                cp_acc    = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end
        end else begin
            cp_acc    = {cp_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) fold_code(cp_acc);
        end
        if (last) begin
            // An end with nothing to send still closes the text with a bare marker.
            if (step_words == 0) emit_byte(8'h00, 1'b0);
            w         = norm_q[$];
            w.last    = 1'b1;
            norm_q[$] = w;
            restart_text();
        end
    endtask

    task automatic check_word();
        t_norm_word w;
        if (norm_q.size() == 0) begin
            $error("unexpected output word: out_byte 8'h%02h byte_present %0b out_last %0b",
                   i_m_tdata, i_m_tuser, i_m_tlast);
            fails++;
        end else begin
            w = norm_q.pop_front();
            checked++;
            if (i_m_tdata !== w.data) begin
                $error("out_byte mismatch: expected 8'h%02h, got 8'h%02h", w.data, i_m_tdata);
                fails++;
            end
            if (i_m_tuser !== w.present) begin
                $error("byte_present mismatch: expected %0b, got %0b", w.present, i_m_tuser);
                fails++;
            end
            if (i_m_tlast !== w.last) begin
                $error("out_last mismatch: expected %0b, got %0b", w.last, i_m_tlast);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_text();
            norm_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) predict_byte(i_s_tdata, i_s_tlast);
            if (i_m_tvalid && i_m_tready) check_word();
        end
        o_pending    <= norm_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

`default_nettype wire

[tb/tb.sv]
// Top of the UTF-8 text normalizer testbench: clock, reset, byte stimulus, receiver
// back-pressure and the verdict. Depends on utf8_text_normalizer and utn_stream_checker.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A run of this many cycles with no word moving on either side means a hang.
    localparam int WATCHDOG_LIMIT = 4000;
    // Length of the random part, in input words.
    localparam int RANDOM_WORDS   = 232;
    // Cycles to wait after the last expected word, to catch strays.
    localparam int TAIL_CYCLES    = 12;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    int fail_count;
    int pending;
    int checked;

    // Idling percentages for the current phase, sender and receiver.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int idle_tab[4]   = '{0, 62, 0, 36};
    int stall_tab[4]  = '{0, 0, 62, 36};

    int words_sent = 0;
    int texts_sent = 0;
    int quiet_cycles = 0;

    logic [7:0] text_q[$];

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    utf8_text_normalizer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    utn_stream_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // The receiver decides each cycle whether to stall, at the phase's rate.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any accepted word on either side restarts the count.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Presents one input word and returns right after the edge that accepts it.
    // Each call starts just after a rising edge, so tvalid gets one assignment per step.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    // Sends the whole text in text_q, flagging its final byte as last.
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        texts_sent++;
    endtask

    // Continuation bytes are mostly well formed; a few are arbitrary, since only
    // their low six bits should matter.
    function automatic logic [7:0] cont_byte();
        logic [7:0] b;
        if ($urandom_range(9) == 0) b = 8'($urandom_range(255));
        else b = 8'h80 | 8'($urandom_range(63));
        return b;
    endfunction

    // Appends one random character to text_q. The mix leans on what the block
    // actually transforms: capitals, white space runs, fullwidth forms, the
    // ideographic space and multi-byte code points, with some raw noise bytes
    // that break sequences and leave them cut off at the end of a text.
    task automatic add_random_char();
        int         pick;
        int         run;
        logic [15:0] fw;
        pick = $urandom_range(99);
        if (pick < 15) begin
            text_q.push_back(8'($urandom_range(127)));
        end else if (pick < 25) begin
            // Capitals plus the characters just outside the range.
            text_q.push_back(8'($urandom_range(8'h5B, 8'h40)));
        end else if (pick < 40) begin
            run = $urandom_range(3, 1);
            repeat (run) text_q.push_back($urandom_range(1) ? 8'h20 : 8'h09);
        end else if (pick < 50) begin
            text_q.push_back(8'($urandom_range(8'hDF, 8'h80)));
            text_q.push_back(cont_byte());
        end else if (pick < 60) begin
            text_q.push_back(8'($urandom_range(8'hEF, 8'hE0)));
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
        end else if (pick < 72) begin
            // Fullwidth block, one code point past each end included.
            fw = 16'($urandom_range(16'hFF5F, 16'hFF00));
            text_q.push_back({4'b1110, fw[15:12]});
            text_q.push_back({2'b10, fw[11:6]});
            text_q.push_back({2'b10, fw[5:0]});
        end else if (pick < 77) begin
            text_q.push_back(8'hE3);
            text_q.push_back(8'h80);
            text_q.push_back(8'h80);
        end else if (pick < 87) begin
            text_q.push_back(8'($urandom_range(8'hFF, 8'hF0)));
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
            text_q.push_back(cont_byte());
        end else begin
            text_q.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int phase;
        int chars;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts, no idling.
        // Leading white space dropped, a tab and space run collapsed, capitals at
        // both ends of the range, and a trailing space that leaves a bare end marker.
        text_q = '{8'h20, 8'h09, 8'h41, 8'h20, 8'h09, 8'h5A, 8'h20};
        send_text();
        // First and last fullwidth forms around an ideographic space.
        text_q = '{8'hEF, 8'hBC, 8'h81, 8'hE3, 8'h80, 8'h80, 8'hEF, 8'hBD, 8'h9E};
        send_text();
        // Largest four-byte value, then a held space ahead of a four-byte
        // character: five words from a single input word, the last one closing.
        text_q = '{8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h20, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text();
        // A stray continuation byte taken as a lead with an overlong result,
        // then a sequence cut off by the end of the text.
        text_q = '{8'h80, 8'hE2, 8'hC0};
        send_text();

        // Random texts across the idling phases.
        while (words_sent < RANDOM_WORDS + 28) begin
            phase = (words_sent - 28) * 4 / RANDOM_WORDS;
            if (phase > 3) phase = 3;
            send_idle_pct = idle_tab[phase];
            stall_pct     = stall_tab[phase];
            text_q.delete();
            chars = $urandom_range(16, 1);
            repeat (chars) add_random_char();
            send_text();
        end
        s_tvalid <= 1'b0;

        // Drain: the checker's count is registered, so the loop steps the clock before it tests.
        do @(posedge clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d texts in %0d input words; checked %0d output words.",
                 texts_sent, words_sent, checked);
        $display("Idling phases covered: none, sender only, receiver only, both.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
design/utn_pkg.sv
design/utn_core.sv
design/utf8_text_normalizer.sv
design/utn_checker.sv
tb/utn_stream_checker.sv
tb/tb.sv
